FILE: rtl/itns_pkg.sv
// ----------------------------------------------------------------------------
// itns_pkg
// Shared types, codes and helpers for the ID table name scanner.
// ----------------------------------------------------------------------------
package itns_pkg;

    // Line phase codes
    localparam logic [2:0] PH_NUM1   = 3'd0;
    localparam logic [2:0] PH_NUM2   = 3'd1;
    localparam logic [2:0] PH_NUM3   = 3'd2;
    localparam logic [2:0] PH_NUM4   = 3'd3;
    localparam logic [2:0] PH_SP     = 3'd4;
    localparam logic [2:0] PH_NAME   = 3'd5;
    localparam logic [2:0] PH_NEXTLN = 3'd6;
    localparam logic [2:0] PH_TAB    = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_VEND = 2'd1;
    localparam logic [1:0] KIND_DEV  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes
    localparam logic REG_VENDOR_KEY = 1'b0;
    localparam logic REG_DEVICE_KEY = 1'b1;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       first_byte;
        logic       final_byte;
    } scan_in_t;

    typedef struct packed {
        logic       have;
        logic [7:0] name_char;
        logic [1:0] kind;
        logic       for_device;
        logic       search_done;
    } scan_res_t;

    // Hex digit value; bit 4 set for a non-hex byte so it never matches a nibble
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]})
            v = 5'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            v = 5'(c - 8'h41 + 8'd10);
        else if (c inside {[8'h61:8'h66]})
            v = 5'(c - 8'h61 + 8'd10);
        return v;
    endfunction

endpackage

FILE: rtl/itns_cfg_regs.sv
// ----------------------------------------------------------------------------
// itns_cfg_regs
// APB register file holding the vendor and device search keys.
// ----------------------------------------------------------------------------
module itns_cfg_regs
    import itns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] vendor_key,
    output logic [15:0] device_key
);

    logic [15:0] vendor_key_reg;
    logic [15:0] device_key_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_key_reg <= '0;
            device_key_reg <= '0;
        end
        else if (wr_en)
        begin
            // low address bits are ignored: decode on the word index only
            if (paddr[2] == REG_VENDOR_KEY)
                vendor_key_reg <= pwdata[15:0];
            else
                device_key_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_DEVICE_KEY)
            prdata = {16'd0, device_key_reg};
        else
            prdata = {16'd0, vendor_key_reg};
    end

    assign vendor_key = vendor_key_reg;
    assign device_key = device_key_reg;

endmodule

FILE: rtl/itns_scan.sv
// ----------------------------------------------------------------------------
// itns_scan
// Per-byte line parser: holds the scan state and decides the result of a byte.
// ----------------------------------------------------------------------------
module itns_scan
    import itns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  scan_in_t    item,
    input  logic [15:0] vendor_key,
    input  logic [15:0] device_key,
    output scan_res_t   res
);

    logic [2:0]  phase_reg, phase_next;
    logic        dev_sec_reg, dev_sec_next;
    logic        fin_reg, fin_next;

    logic [2:0]  ph;
    logic        dsec;
    logic        fin;
    logic [15:0] key;
    logic [3:0]  nib;
    logic [7:0]  b;

    always_comb
    begin
        b    = item.table_byte;
        ph   = item.first_byte ? PH_NUM1 : phase_reg;
        dsec = item.first_byte ? 1'b0 : dev_sec_reg;
        fin  = item.first_byte ? 1'b0 : fin_reg;
        key  = dsec ? device_key : vendor_key;
        case (ph[1:0])
            2'd0:    nib = key[15:12];
            2'd1:    nib = key[11:8];
            2'd2:    nib = key[7:4];
            default: nib = key[3:0];
        endcase

        phase_next   = ph;
        dev_sec_next = dsec;
        fin_next     = fin;
        res          = '0;

        if (!fin)
        begin
            if (b == CH_LF)
            begin
                if (ph == PH_NAME)
                begin
                    res.have = 1'b1;
                    if (!dsec)
                    begin
                        res.kind     = KIND_VEND;
                        dev_sec_next = 1'b1;
                    end
                    else
                    begin
                        res.kind        = KIND_DEV;
                        res.for_device  = 1'b1;
                        res.search_done = 1'b1;
                        fin_next        = 1'b1;
                    end
                end
                phase_next = dev_sec_next ? PH_TAB : PH_NUM1;
            end
            else if (ph == PH_NEXTLN)
            begin
                phase_next = PH_NEXTLN;
            end
            else if (b == CH_TAB)
            begin
                phase_next = (dsec && ph == PH_TAB) ? PH_NUM1 : PH_NEXTLN;
            end
            else if (ph == PH_TAB)
            begin
                // non-tab line inside the device section: vendor block is over
                res.have        = 1'b1;
                res.kind        = KIND_NONE;
                res.search_done = 1'b1;
                fin_next        = 1'b1;
            end
            else if (b == CH_HASH && ph == PH_NUM1)
            begin
                phase_next = PH_NEXTLN;
            end
            else if (ph <= PH_NUM4)
            begin
                if ({1'b0, nib} == hex_value(b))
                    phase_next = ph + 3'd1;
                else
                    phase_next = PH_NEXTLN;
            end
            else if (ph == PH_SP && b == CH_SPACE)
            begin
                phase_next = PH_SP;
            end
            else if (ph == PH_SP || ph == PH_NAME)
            begin
                phase_next     = PH_NAME;
                res.have       = 1'b1;
                res.kind       = KIND_CHAR;
                res.name_char  = b;
                res.for_device = dsec;
            end
            else
            begin
                phase_next = PH_NEXTLN;
            end

            if (item.final_byte && !fin_next)
            begin
                res.have        = 1'b1;
                res.kind        = KIND_NONE;
                res.name_char   = '0;
                res.for_device  = 1'b0;
                res.search_done = 1'b1;
                fin_next        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NUM1;
            dev_sec_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            dev_sec_reg <= dev_sec_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

FILE: rtl/id_table_name_scanner_core.sv
// ----------------------------------------------------------------------------
// id_table_name_scanner_core
// Streams the name of a vendor/device pair found in an ID-list text.
//
//   channel  | dir | contents
//   s_axis   | in  | tdata = table_byte, tuser = first_byte, tlast = final_byte
//   m_axis   | out | tdata = name_char, tuser = {for_device, kind},
//            |     | tlast = search_done
//   apb      | in  | 0x0 vendor_key, 0x4 device_key
//
// One byte per cycle while m_axis is not stalled: input register, parse logic, result register.
// A result reaches m_axis from the result register after its byte has passed the input register.
// Bytes that yield no result are dropped silently in the parse stage.
// rst_n clears both stage valids, the scan state and the keys.
// A stalled m_axis holds the result; the input register holds until it drains.
// ----------------------------------------------------------------------------
module id_table_name_scanner_core
    import itns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] table_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] name_char
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] for_device
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg;
    scan_in_t    in_item_reg;
    logic        out_valid_reg;
    scan_res_t   out_res_reg;
    scan_res_t   res;
    logic        advance;
    logic [15:0] vendor_key;
    logic [15:0] device_key;

    itns_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .vendor_key (vendor_key),
        .device_key (device_key)
    );

    itns_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (in_item_reg),
        .vendor_key (vendor_key),
        .device_key (device_key),
        .res        (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.table_byte <= s_axis_tdata;
            in_item_reg.first_byte <= s_axis_tuser;
            in_item_reg.final_byte <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.have;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.have)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.name_char;
    assign m_axis_tuser  = {out_res_reg.for_device, out_res_reg.kind};
    assign m_axis_tlast  = out_res_reg.search_done;

endmodule

FILE: rtl/itns_checker.sv
// ----------------------------------------------------------------------------
// itns_checker
// Port-level checks for the ID table name scanner, bound to the top level.
// ----------------------------------------------------------------------------
module itns_checker
    import itns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [2:0] m_axis_tuser,
    input  logic       m_axis_tlast,
    input  logic       pready
);

    // tlast marks exactly the search-ending kinds
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast ==
            (m_axis_tuser[1:0] == KIND_DEV || m_axis_tuser[1:0] == KIND_NONE)))
        else $error("tlast does not match result kind");

    // end marks carry no character
    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] != KIND_CHAR) |-> (m_axis_tdata == 8'd0))
        else $error("end mark with nonzero character");

    // device flag agrees with kind
    a_dev_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser[1:0] == KIND_DEV) ? m_axis_tuser[2] :
             (m_axis_tuser[1:0] == KIND_CHAR) || !m_axis_tuser[2]))
        else $error("for_device inconsistent with kind");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled transfer changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind id_table_name_scanner_core itns_checker u_itns_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
